// ----- hdl/wtml_pkg.sv -----
// Shared types, constants and byte classification for the word tokenizer.
// Has no dependencies; the core and the store import it.
package wtml_pkg;

	// Default size of the word store in bytes.
	localparam int MAX_WORD_DEF = 32;

	// Width of the length register and of the reported word length.
	localparam int CFG_W = 6;

	// Reset value of the length limit.
	localparam logic [CFG_W-1:0] MAX_LEN_RESET = 6'd32;

	// The hyphen byte, which continues a word but is dropped at its tail.
	localparam logic [7:0] HYPHEN = 8'h2D;

	// Scan mode of the tokenizer.
	typedef enum logic [1:0] {
		MODE_SKIP    = 2'd0,
		MODE_WORD    = 2'd1,
		MODE_DISCARD = 2'd2
	} scan_mode_t;

	// Sequencer states: take items, read a stored byte, present a result.
	typedef enum logic [1:0] {
		SEQ_IDLE = 2'd0,
		SEQ_READ = 2'd1,
		SEQ_SEND = 2'd2
	} seq_state_t;

	// Input command codes.
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_EOT  = 1'b1;

	// White space in the C locale: tab through carriage return, and blank.
	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// Punctuation in the C locale: printable bytes that are not alphanumeric.
	function automatic logic is_punct(input logic [7:0] c);
		return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
		       (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
	endfunction

endpackage

// ----- hdl/wtml_ifs.sv -----
// Valid/ready channel interfaces for text items and word byte items.
// Depends on nothing; payload widths are fixed by the block's fields.
interface wtml_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] char_in;

	modport source (output valid, output command, output char_in, input ready);
	modport sink (input valid, input command, input char_in, output ready);
endinterface

interface wtml_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic       word_end;
	logic [5:0] word_length;

	modport source (output valid, output char_out, output word_end, output word_length,
		input ready);
	modport sink (input valid, input char_out, input word_end, input word_length,
		output ready);
endinterface

// ----- hdl/word_tokenizer_max_length_core.sv -----
// Word tokenizer: splits text bytes into words, drops trailing hyphens and discards
// words longer than the programmed limit. Depends on wtml_pkg, wtml_ifs.sv, wtml_store.sv.
// The first byte of a word is offered once the sequencer has passed its read state and
// the store has registered the byte. A text item that ends a word replays the stored
// bytes, reading then sending each in turn and waiting on output stalls; text input waits until the last byte is taken.
// Reset clears the scan mode and lengths and sets the limit to 32; the store is not reset.
module word_tokenizer_max_length_core #(
	parameter int MAX_WORD = wtml_pkg::MAX_WORD_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [wtml_pkg::CFG_W-1:0]  cfg_wdata,
	wtml_in_if.sink                     text,
	wtml_out_if.source                  words
);
	import wtml_pkg::*;

	localparam int ADDR_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
	localparam int LEN_W  = $clog2(MAX_WORD + 1);
	localparam int CMP_W  = (LEN_W > CFG_W) ? LEN_W : CFG_W;

	logic [CFG_W-1:0] max_len_q;
	scan_mode_t       mode_q, mode_d;
	seq_state_t       state_q, state_d;
	logic [LEN_W-1:0] stored_len_q, stored_len_d;
	logic [LEN_W-1:0] lbh_len_q, lbh_len_d;
	logic [LEN_W-1:0] emit_len_q;
	logic [LEN_W-1:0] idx_q;

	logic             take;
	logic             start_emit;
	logic             send_done;
	logic             last_byte;
	logic             space, punct, sep;
	logic [CMP_W-1:0] limit;
	logic [LEN_W-1:0] base;
	logic             fits;
	logic             we;
	logic             re;
	logic [7:0]       rdata;
	logic [CMP_W-1:0] emit_len_ext;

	// Length limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	// Byte classes and the saturated limit.
	assign space = is_space(text.char_in);
	assign punct = is_punct(text.char_in);
	assign sep   = space || (punct && (text.char_in != HYPHEN));
	assign limit = (CMP_W'(max_len_q) > CMP_W'(MAX_WORD)) ? CMP_W'(MAX_WORD)
	                                                       : CMP_W'(max_len_q);

	// A new word starts at offset zero; otherwise append after the stored bytes.
	assign base = (mode_q == MODE_SKIP) ? '0 : stored_len_q;
	assign fits = CMP_W'(base) < limit;
	assign take = text.valid && text.ready;

	// Scan mode and length update for one accepted item.
	always_comb begin
		mode_d       = mode_q;
		stored_len_d = stored_len_q;
		lbh_len_d    = lbh_len_q;
		start_emit   = 1'b0;
		we           = 1'b0;
		if (take) begin
			if (text.command == CMD_EOT) begin
				start_emit   = (mode_q == MODE_WORD) && (lbh_len_q != '0);
				mode_d       = MODE_SKIP;
				stored_len_d = '0;
				lbh_len_d    = '0;
			end else begin
				unique case (mode_q)
					MODE_SKIP, MODE_WORD: begin
						if (mode_q == MODE_WORD && sep) begin
							start_emit   = (lbh_len_q != '0);
							mode_d       = MODE_SKIP;
							stored_len_d = '0;
							lbh_len_d    = '0;
						end else if (mode_q == MODE_SKIP && (space || punct)) begin
							mode_d = MODE_SKIP;
						end else if (fits) begin
							we           = 1'b1;
							mode_d       = MODE_WORD;
							stored_len_d = base + LEN_W'(1);
							if (mode_q == MODE_SKIP) begin
								lbh_len_d = '0;
							end
							if (text.char_in != HYPHEN) begin
								lbh_len_d = base + LEN_W'(1);
							end
						end else begin
							mode_d       = MODE_DISCARD;
							stored_len_d = '0;
							lbh_len_d    = '0;
						end
					end
					MODE_DISCARD: begin
						if (space) begin
							mode_d       = MODE_SKIP;
							stored_len_d = '0;
							lbh_len_d    = '0;
						end
					end
					default: begin
						mode_d       = MODE_SKIP;
						stored_len_d = '0;
						lbh_len_d    = '0;
					end
				endcase
			end
		end
	end

	// Replay control: the last byte is the one before the emitted length.
	assign last_byte = ({1'b0, idx_q} + (LEN_W + 1)'(1)) == {1'b0, emit_len_q};
	assign send_done = (state_q == SEQ_SEND) && words.ready;

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SEQ_IDLE: begin
				if (start_emit) begin
					state_d = SEQ_READ;
				end
			end
			SEQ_READ: begin
				state_d = SEQ_SEND;
			end
			SEQ_SEND: begin
				if (words.ready) begin
					state_d = last_byte ? SEQ_IDLE : SEQ_READ;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		text.ready  = 1'b0;
		words.valid = 1'b0;
		re          = 1'b0;
		unique case (state_q)
			SEQ_IDLE: text.ready  = 1'b1;
			SEQ_READ: re          = 1'b1;
			SEQ_SEND: words.valid = 1'b1;
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= SEQ_IDLE;
			mode_q       <= MODE_SKIP;
			stored_len_q <= '0;
			lbh_len_q    <= '0;
			idx_q        <= '0;
			emit_len_q   <= '0;
		end else begin
			state_q      <= state_d;
			mode_q       <= mode_d;
			stored_len_q <= stored_len_d;
			lbh_len_q    <= lbh_len_d;
			if (start_emit) begin
				idx_q      <= '0;
				emit_len_q <= lbh_len_q;
			end else if (send_done) begin
				idx_q <= idx_q + LEN_W'(1);
			end
		end
	end

	// Word byte storage.
	wtml_store #(
		.MAX_WORD (MAX_WORD),
		.ADDR_W   (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (base[ADDR_W-1:0]),
		.wdata (text.char_in),
		.re    (re),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (rdata)
	);

	// Result item fields.
	assign emit_len_ext      = CMP_W'(emit_len_q);
	assign words.char_out    = rdata;
	assign words.word_end    = last_byte;
	assign words.word_length = emit_len_ext[5:0];
endmodule

// ----- hdl/wtml_store.sv -----
// Word store: one write port and one read port with registered read data.
// Depends on wtml_pkg for the default depth.
module wtml_store #(
	parameter int MAX_WORD = wtml_pkg::MAX_WORD_DEF,
	parameter int ADDR_W   = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);
	import wtml_pkg::*;

	logic [7:0] mem_q [MAX_WORD];
	logic [7:0] rdata_q;

	// Write a byte of the current word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read data is held until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
